// ===== rtl/dnt_pkg.sv =====
// ----------------------------------------------------------------------------
// dnt_pkg: shared types and codes for the name text to wire converter
// Result entry layout, per-transaction result batch, kinds and status codes.
// ----------------------------------------------------------------------------
package dnt_pkg;

  // Most results one input transaction can cause: three label writes from a
  // cut-short escape, the final length byte, the root byte and the status.
  localparam int NRES  = 6;
  localparam int CNT_W = $clog2(NRES + 1);
  localparam int IDX_W = $clog2(NRES);

  // Result kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NAME_LONG   = 3'd1;
  localparam logic [2:0] ST_EMPTY       = 3'd2;
  localparam logic [2:0] ST_LABEL_LONG  = 3'd3;
  localparam logic [2:0] ST_EMPTY_LABEL = 3'd4;
  localparam logic [2:0] ST_BAD_ESC     = 3'd5;

  // Special characters
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [3:0] CH_DIGIT_HI = 4'h3;  // upper nibble of '0'..'9'

  typedef struct packed {
    logic       kind;
    logic [7:0] wbyte;
    logic [7:0] pos;
    logic [2:0] status;
  } dnt_res_t;

  typedef struct packed {
    dnt_res_t [NRES-1:0] res;
    logic [CNT_W-1:0]    cnt;
  } dnt_batch_t;

endpackage

// ===== rtl/dnt_step.sv =====
// ----------------------------------------------------------------------------
// dnt_step: per-character parser state and result generation
// Holds the name state and, for one character, works out the next state and
// the ordered list of wire writes and status it causes.
// ----------------------------------------------------------------------------
module dnt_step
  import dnt_pkg::*;
#(
  parameter int MAX_LABEL = 63,
  parameter int MAX_NAME  = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_ch,
  input  logic       in_has,
  input  logic       in_last,
  output dnt_batch_t batch
);

  localparam logic [1:0] PH_NONE = 2'd0;  // no escape open
  localparam logic [1:0] PH_BSL  = 2'd1;  // after backslash
  localparam logic [1:0] PH_ONE  = 2'd2;  // one digit held
  localparam logic [1:0] PH_TWO  = 2'd3;  // two digits held

  localparam int LC_W = 6;

  typedef struct packed {
    logic [7:0]      wp;   // next label byte position
    logic [7:0]      ls;   // open label's length byte position
    logic [LC_W-1:0] lc;   // bytes in open label
    logic [1:0]      cc;   // characters seen, saturating at two
    logic [1:0]      ph;
    logic [3:0]      d0;
    logic [3:0]      d1;
    logic [2:0]      err;
    logic            eod;  // last significant char was a bare dot
  } dnt_state_t;

  typedef struct packed {
    dnt_state_t st;
    logic       emit;
    dnt_res_t   res;
  } dnt_op_t;

  localparam dnt_state_t ST_RESET = '{wp: 8'd1, ls: 8'd0, lc: '0, cc: 2'd0,
                                      ph: PH_NONE, d0: 4'd0, d1: 4'd0,
                                      err: ST_OK, eod: 1'b0};

  function automatic dnt_res_t f_mk(logic k, logic [7:0] b, logic [7:0] p,
                                    logic [2:0] s);
    dnt_res_t r;
    r.kind   = k;
    r.wbyte  = b;
    r.pos    = p;
    r.status = s;
    return r;
  endfunction

  function automatic dnt_batch_t f_push(dnt_batch_t bt, logic emit, dnt_res_t r);
    dnt_batch_t o;
    o = bt;
    if (emit) begin
      o.res[bt.cnt[IDX_W-1:0]] = r;
      o.cnt = bt.cnt + 1'b1;
    end
    return o;
  endfunction

  function automatic dnt_op_t f_label_byte(dnt_state_t s, logic [7:0] b);
    dnt_op_t o;
    o.st   = s;
    o.emit = 1'b0;
    o.res  = f_mk(KIND_WRITE, b, s.wp, ST_OK);
    if (s.err == ST_OK) begin
      if (s.lc >= LC_W'(MAX_LABEL)) begin
        o.st.err = ST_LABEL_LONG;
      end else if ({1'b0, s.wp} + 9'd2 > 9'(MAX_NAME)) begin
        o.st.err = ST_NAME_LONG;
      end else begin
        o.emit   = 1'b1;
        o.st.wp  = s.wp + 8'd1;
        o.st.lc  = s.lc + 1'b1;
        o.st.eod = 1'b0;
      end
    end
    return o;
  endfunction

  function automatic dnt_op_t f_close_label(dnt_state_t s);
    dnt_op_t o;
    o.st   = s;
    o.emit = 1'b0;
    o.res  = f_mk(KIND_WRITE, {{(8-LC_W){1'b0}}, s.lc}, s.ls, ST_OK);
    if (s.err == ST_OK) begin
      if (s.lc == '0) begin
        // a single leading dot is the root name; any other empty label fails
        if (s.cc == 2'd1 && s.wp == 8'd1 && s.ls == 8'd0) begin
          o.st.eod = 1'b1;
        end else begin
          o.st.err = ST_EMPTY_LABEL;
        end
      end else begin
        o.emit   = 1'b1;
        o.st.ls  = s.wp;
        o.st.wp  = s.wp + 8'd1;
        o.st.lc  = '0;
        o.st.eod = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic dnt_op_t f_plain_char(dnt_state_t s, logic [7:0] c);
    dnt_op_t o;
    o.st   = s;
    o.emit = 1'b0;
    o.res  = f_mk(KIND_WRITE, c, s.wp, ST_OK);
    if (s.err == ST_OK) begin
      if (c == CH_DOT) begin
        o = f_close_label(s);
      end else if (c == CH_BSL) begin
        o.st.ph  = PH_BSL;
        o.st.eod = 1'b0;
      end else begin
        o = f_label_byte(s, c);
      end
    end
    return o;
  endfunction

  dnt_state_t st_r, st_nxt;
  dnt_state_t s;
  dnt_batch_t bt;
  dnt_op_t    op;
  logic       is_dig;
  logic [9:0] dec_v;
  logic [7:0] len;

  always_comb begin
    s      = st_r;
    bt     = '0;
    op     = '0;
    len    = 8'd0;
    is_dig = (in_ch >= 8'h30) && (in_ch <= 8'h39);
    dec_v  = 10'(s.d0) * 10'd100 + 10'(s.d1) * 10'd10 + 10'(in_ch[3:0]);

    if (in_has) begin
      if (s.cc != 2'd2) begin
        s.cc = s.cc + 2'd1;
      end
      if (s.err == ST_OK) begin
        case (s.ph)
          PH_BSL: begin
            s.ph = PH_NONE;
            if (is_dig) begin
              s.d0 = in_ch[3:0];
              s.ph = PH_ONE;
            end else begin
              op = f_label_byte(s, in_ch); s = op.st; bt = f_push(bt, op.emit, op.res);
            end
          end
          PH_ONE: begin
            if (is_dig) begin
              s.d1 = in_ch[3:0];
              s.ph = PH_TWO;
            end else begin
              // escape cut short: first digit becomes literal
              s.ph = PH_NONE;
              op = f_label_byte(s, {CH_DIGIT_HI, s.d0}); s = op.st;
              bt = f_push(bt, op.emit, op.res);
              op = f_plain_char(s, in_ch); s = op.st; bt = f_push(bt, op.emit, op.res);
            end
          end
          PH_TWO: begin
            s.ph = PH_NONE;
            if (is_dig) begin
              op = f_label_byte(s, dec_v[7:0]); s = op.st;
              bt = f_push(bt, op.emit, op.res);
            end else begin
              op = f_label_byte(s, {CH_DIGIT_HI, s.d0}); s = op.st;
              bt = f_push(bt, op.emit, op.res);
              op = f_label_byte(s, {CH_DIGIT_HI, s.d1}); s = op.st;
              bt = f_push(bt, op.emit, op.res);
              op = f_plain_char(s, in_ch); s = op.st; bt = f_push(bt, op.emit, op.res);
            end
          end
          default: begin
            if (s.eod && s.wp == 8'd1 && s.ls == 8'd0) begin
              s.err = ST_EMPTY_LABEL;  // anything after a lone root dot
            end else begin
              op = f_plain_char(s, in_ch); s = op.st; bt = f_push(bt, op.emit, op.res);
            end
          end
        endcase
      end
    end

    if (in_last) begin
      if (s.err == ST_OK) begin
        case (s.ph)
          PH_BSL: s.err = ST_BAD_ESC;
          PH_ONE: begin
            s.ph = PH_NONE;
            op = f_label_byte(s, {CH_DIGIT_HI, s.d0}); s = op.st;
            bt = f_push(bt, op.emit, op.res);
          end
          PH_TWO: begin
            s.ph = PH_NONE;
            op = f_label_byte(s, {CH_DIGIT_HI, s.d0}); s = op.st;
            bt = f_push(bt, op.emit, op.res);
            op = f_label_byte(s, {CH_DIGIT_HI, s.d1}); s = op.st;
            bt = f_push(bt, op.emit, op.res);
          end
          default: ;
        endcase
      end
      if (s.err == ST_OK) begin
        if (s.cc == 2'd0) begin
          s.err = ST_EMPTY;
        end else if (s.eod && s.wp == 8'd1 && s.ls == 8'd0) begin
          bt  = f_push(bt, 1'b1, f_mk(KIND_WRITE, 8'd0, 8'd0, ST_OK));
          len = 8'd1;
        end else if (s.eod) begin
          bt  = f_push(bt, 1'b1, f_mk(KIND_WRITE, 8'd0, s.ls, ST_OK));
          len = s.ls + 8'd1;
        end else if (s.lc == '0) begin
          s.err = ST_EMPTY_LABEL;
        end else begin
          bt  = f_push(bt, 1'b1,
                       f_mk(KIND_WRITE, {{(8-LC_W){1'b0}}, s.lc}, s.ls, ST_OK));
          bt  = f_push(bt, 1'b1, f_mk(KIND_WRITE, 8'd0, s.wp, ST_OK));
          len = s.wp + 8'd1;
        end
      end
      bt = f_push(bt, 1'b1, f_mk(KIND_STATUS, (s.err == ST_OK) ? len : 8'd0,
                                 8'd0, s.err));
      s = ST_RESET;
    end

    st_nxt = s;
    batch  = bt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== rtl/dnt_outq.sv =====
// ----------------------------------------------------------------------------
// dnt_outq: result register and drain sequencer
// Captures the result batch of one transaction and hands the entries out one
// per cycle while res_ready is high; takes the next batch as the last entry leaves.
// ----------------------------------------------------------------------------
module dnt_outq
  import dnt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  dnt_batch_t batch,
  output logic       load_ok,
  output logic       res_valid,
  input  logic       res_ready,
  output dnt_res_t   res,
  output logic       res_last
);

  dnt_res_t [NRES-1:0] ent_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    idx_r;
  logic [CNT_W-1:0]    idx_inc;

  assign idx_inc   = idx_r + 1'b1;
  assign res_valid = (idx_r != cnt_r);
  assign res_last  = (idx_inc == cnt_r);
  assign res       = ent_r[idx_r[IDX_W-1:0]];
  assign load_ok   = !res_valid || (res_last && res_ready);

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= batch.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= batch.cnt;
      idx_r <= '0;
    end else if (res_valid && res_ready) begin
      idx_r <= idx_inc;
    end
  end

endmodule

// ===== rtl/dns_name_text_to_wire.sv =====
// ----------------------------------------------------------------------------
// dns_name_text_to_wire: domain name text to wire format converter
// Takes a dotted name one character per transaction and emits addressed
// wire-buffer byte writes followed by a final status transaction.
//
//   channel | dir | tdata                              | tuser    | tlast
//   --------+-----+------------------------------------+----------+---------
//   in_     | in  | [7:0] ch                           | has_char | last
//   out_    | out | [7:0] wire_byte [15:8] wire_pos    | kind     | run_last
//           |     | [18:16] status, [23:19] zero       |          |
//
// The character is parsed in the cycle it is accepted and all of its
// results land in the result register, which hands them out one at a time
// (a transaction causes at most six results, when a two-digit escape cut
// short by a plain character ends the name); the next input is taken in
// the cycle the last of them leaves, so single-result streams run at full
// rate. Reset (rst_n low, synchronous) returns the parser to the start of
// a name and empties the result register. Output stalls back up to
// in_tready.
// ----------------------------------------------------------------------------
module dns_name_text_to_wire
  import dnt_pkg::*;
#(
  parameter int MAX_LABEL = 63,   // longest label, 1..63
  parameter int MAX_NAME  = 255   // longest wire name incl. root byte, 2..255
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // has_char
  input  logic        in_tlast,   // last

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] wire_byte, [15:8] wire_pos, [18:16] status
  output logic        out_tuser,  // kind: 0 write, 1 status
  output logic        out_tlast   // run_last
);

  logic       in_fire;
  dnt_batch_t batch;
  dnt_res_t   res;

  assign in_fire = in_tvalid && in_tready;

  // Parser: state lives here, updated once per accepted transaction.
  dnt_step #(
    .MAX_LABEL (MAX_LABEL),
    .MAX_NAME  (MAX_NAME)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_fire),
    .in_ch   (in_tdata),
    .in_has  (in_tuser),
    .in_last (in_tlast),
    .batch   (batch)
  );

  // Result register: drains the batch one transaction per cycle while out_tready is high.
  dnt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .batch     (batch),
    .load_ok   (in_tready),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res),
    .res_last  (out_tlast)
  );

  assign out_tdata = {5'd0, res.status, res.pos, res.wbyte};
  assign out_tuser = res.kind;

  // Input is only taken alongside a pending result when that is the last one.
  a_ready_only_on_last : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && out_tvalid) |-> out_tlast)
    else $error("in_tready raised with more than one result pending");

  // The status always closes the run of results for its transaction.
  a_status_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("status transaction not marked last");

  // A failed name reports no length and position zero.
  a_error_zero_len : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser && out_tdata[18:16] != ST_OK)
      |-> (out_tdata[15:0] == 16'd0))
    else $error("error status carries a nonzero length or position");

endmodule

// ===== dv/tb_dns_name_text_to_wire.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dns_name_text_to_wire: self-checking bench for the name text converter
// Feeds dotted names one character per transaction and checks every wire
// write and final status against an in-bench model of the parser.
// ----------------------------------------------------------------------------
module tb_dns_name_text_to_wire;
  import dnt_pkg::*;

  localparam int NAME_LABEL_MAX = 63;
  localparam int NAME_WIRE_MAX  = 255;
  localparam int RAND_ITEMS     = 120;    // random-phase input transactions
  localparam int QUIET_FROM     = 90;     // no idling past this point
  localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 20;

  // Escape parser states
  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_SLASH = 2'd1;  // backslash seen
  localparam logic [1:0] ESC_ONE   = 2'd2;  // one digit held
  localparam logic [1:0] ESC_TWO   = 2'd3;  // two digits held

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  typedef struct {
    logic       kind;
    logic [7:0] wbyte;
    logic [7:0] pos;
    logic [2:0] status;
    logic       run_last;
  } wire_res_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the parser state, turns each accepted
  // input into the writes/status it should cause, and checks results in order.
  // --------------------------------------------------------------------------
  class wire_scoreboard;
    wire_res_t   pending[$];   // results still owed by the DUT
    wire_res_t   step_res[$];  // results of the transaction being predicted
    int          errors;
    int          n_writes;
    int          st_tally[8];

    logic [8:0]  nxt_pos;
    logic [7:0]  lbl_start;
    logic [7:0]  lbl_len;
    logic [9:0]  chars_seen;
    logic [1:0]  esc_state;
    logic [3:0]  esc_dig[2];
    logic [2:0]  err_code;
    logic        dot_last;

    function new();
      errors   = 0;
      n_writes = 0;
      foreach (st_tally[i]) st_tally[i] = 0;
      clear_name();
    endfunction

    function void clear_name();
      nxt_pos    = 9'd1;
      lbl_start  = 8'd0;
      lbl_len    = 8'd0;
      chars_seen = 10'd0;
      esc_state  = ESC_NONE;
      esc_dig[0] = 4'd0;
      esc_dig[1] = 4'd0;
      err_code   = ST_OK;
      dot_last   = 1'b0;
    endfunction

    function void put_res(logic kind, logic [7:0] b, logic [7:0] p, logic [2:0] st);
      wire_res_t r;
      r.kind     = kind;
      r.wbyte    = b;
      r.pos      = p;
      r.status   = st;
      r.run_last = 1'b0;
      step_res.push_back(r);
    endfunction

    function void set_err(logic [2:0] code);
      if (err_code == ST_OK) err_code = code;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // nothing written yet beyond the root length slot
    function bit at_root();
      return nxt_pos == 9'd1 && lbl_start == 8'd0;
    endfunction

    function void label_out(logic [7:0] b);
      if (err_code != ST_OK) return;
      if (lbl_len >= NAME_LABEL_MAX) set_err(ST_LABEL_LONG);
      else if (int'(nxt_pos) + 2 > NAME_WIRE_MAX) set_err(ST_NAME_LONG);
      else begin
        put_res(KIND_WRITE, b, nxt_pos[7:0], ST_OK);
        nxt_pos  = nxt_pos + 9'd1;
        lbl_len  = lbl_len + 8'd1;
        dot_last = 1'b0;
      end
    endfunction

    // unescaped dot: back-fill the length byte, open the next label
    function void close_label();
      if (err_code != ST_OK) return;
      if (lbl_len == 8'd0) begin
        if (chars_seen == 10'd1 && at_root()) dot_last = 1'b1;
        else set_err(ST_EMPTY_LABEL);
        return;
      end
      put_res(KIND_WRITE, lbl_len, lbl_start, ST_OK);
      lbl_start = nxt_pos[7:0];
      nxt_pos   = nxt_pos + 9'd1;
      lbl_len   = 8'd0;
      dot_last  = 1'b1;
    endfunction

    function void plain_char(logic [7:0] c);
      if (err_code != ST_OK) return;
      if (c == CH_DOT) close_label();
      else if (c == CH_BSL) begin
        esc_state = ESC_SLASH;
        dot_last  = 1'b0;
      end else label_out(c);
    endfunction

    function void take_char(logic [7:0] c);
      int v;
      if (err_code != ST_OK) return;
      case (esc_state)
        ESC_SLASH: begin
          esc_state = ESC_NONE;
          if (is_digit(c)) begin
            esc_dig[0] = 4'(c - CH_ZERO);
            esc_state  = ESC_ONE;
          end else label_out(c);
        end
        ESC_ONE: begin
          if (is_digit(c)) begin
            esc_dig[1] = 4'(c - CH_ZERO);
            esc_state  = ESC_TWO;
          end else begin
            // escape cut short: first digit becomes literal
            esc_state = ESC_NONE;
            label_out(CH_ZERO + 8'(esc_dig[0]));
            plain_char(c);
          end
        end
        ESC_TWO: begin
          esc_state = ESC_NONE;
          if (is_digit(c)) begin
            v = int'(esc_dig[0]) * 100 + int'(esc_dig[1]) * 10 + int'(c - CH_ZERO);
            label_out(8'(v));
          end else begin
            label_out(CH_ZERO + 8'(esc_dig[0]));
            label_out(CH_ZERO + 8'(esc_dig[1]));
            plain_char(c);
          end
        end
        default: begin
          // anything after a leading lone dot is an empty label
          if (dot_last && at_root()) begin
            set_err(ST_EMPTY_LABEL);
            return;
          end
          plain_char(c);
        end
      endcase
    endfunction

    function void end_name();
      int wlen;
      wlen = 0;
      if (err_code == ST_OK) begin
        case (esc_state)
          ESC_SLASH: set_err(ST_BAD_ESC);
          ESC_ONE: begin
            esc_state = ESC_NONE;
            label_out(CH_ZERO + 8'(esc_dig[0]));
          end
          ESC_TWO: begin
            esc_state = ESC_NONE;
            label_out(CH_ZERO + 8'(esc_dig[0]));
            label_out(CH_ZERO + 8'(esc_dig[1]));
          end
          default: ;
        endcase
      end
      if (err_code == ST_OK) begin
        if (chars_seen == 10'd0) set_err(ST_EMPTY);
        else if (dot_last && at_root()) begin
          put_res(KIND_WRITE, 8'd0, 8'd0, ST_OK);
          wlen = 1;
        end else if (dot_last) begin
          put_res(KIND_WRITE, 8'd0, lbl_start, ST_OK);
          wlen = int'(lbl_start) + 1;
        end else if (lbl_len == 8'd0) set_err(ST_EMPTY_LABEL);
        else begin
          put_res(KIND_WRITE, lbl_len, lbl_start, ST_OK);
          put_res(KIND_WRITE, 8'd0, nxt_pos[7:0], ST_OK);
          wlen = int'(nxt_pos) + 1;
        end
      end
      put_res(KIND_STATUS, (err_code == ST_OK) ? 8'(wlen) : 8'd0, 8'd0, err_code);
    endfunction

    // accepted input transaction -> expected results
    function void note_input(logic [7:0] ch, logic has_char, logic last);
      step_res.delete();
      if (has_char) begin
        if (chars_seen != 10'h3FF) chars_seen = chars_seen + 10'd1;
        take_char(ch);
      end
      if (last) begin
        end_name();
        clear_name();
      end
      if (step_res.size() > 0) step_res[step_res.size() - 1].run_last = 1'b1;
      foreach (step_res[i]) pending.push_back(step_res[i]);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_result(logic kind, logic [23:0] data, logic run_last);
      wire_res_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing expected: kind=%0d data=%06h", kind, data));
        return;
      end
      want = pending.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", kind, want.kind));
      if (data[7:0] !== want.wbyte)
        report($sformatf("wire_byte %02h, expected %02h", data[7:0], want.wbyte));
      if (data[15:8] !== want.pos)
        report($sformatf("wire_pos %0d, expected %0d", data[15:8], want.pos));
      if (data[18:16] !== want.status)
        report($sformatf("status %0d, expected %0d", data[18:16], want.status));
      if (data[23:19] !== 5'd0)
        report($sformatf("tdata pad bits %02h not zero", data[23:19]));
      if (run_last !== want.run_last)
        report($sformatf("run_last %0d, expected %0d", run_last, want.run_last));
      if (want.kind == KIND_WRITE) n_writes++;
      else st_tally[want.status]++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [7:0] ch
  logic        in_tuser;     // has_char
  logic        in_tlast;     // last
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;    // [7:0] wire_byte, [15:8] wire_pos, [18:16] status
  logic        out_tuser;    // kind
  logic        out_tlast;    // run_last

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dns_name_text_to_wire #(
    .MAX_LABEL (NAME_LABEL_MAX),
    .MAX_NAME  (NAME_WIRE_MAX)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  wire_scoreboard sb;

  int   n_items = 0;      // accepted transactions carrying a char or an end
  int   n_names = 0;
  int   cycles  = 0;
  int   rx_stall = 0;
  logic quiet = 1'b0;     // final stretch: no idling on either side
  logic calm  = 1'b0;     // random idle-free stretches
  logic hold  = 1'b0;     // long receiver hold-off
  logic [7:0] name_q[$];  // characters of the name being built

  // Watchdog plus the calm/busy phase toggle. Calm is redrawn at random
  // so gaps land at all phases of the parser's work.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 64 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycles >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycles, sb.pending.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: ready drops in random bursts, or for the long hold-off.
  always @(negedge clk) begin
    if (hold) out_tready <= 1'b0;
    else if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall = rx_stall - 1;
    end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      rx_stall = $urandom_range(0, 9);
    end else out_tready <= 1'b1;
  end

  // Result monitor: every accepted transaction is checked in order.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata, out_tlast);
  end

  // Pressure: once into the random part, stop taking results for a long
  // stretch while the sender keeps offering; the result register fills and
  // in_tready must drop.
  initial begin
    wait (n_items >= 40);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // One input transaction, with an optional idle burst before it.
  task automatic push_char(logic [7:0] c, logic has_char, logic last);
    int gap;
    gap = (!quiet && !calm && !hold && $urandom_range(0, 5) == 0) ?
          $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= has_char;
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_input(c, has_char, last);
    if (has_char || last) n_items++;
  endtask

  task automatic send_text(string s, bit last_on_final);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], 1'b1, last_on_final && (i == s.len() - 1));
    if (last_on_final) n_names++;
  endtask

  // Sends name_q; the end rides on the last char or on a char-less item.
  // Ignored (no char, no end) items are sprinkled in at random.
  task automatic send_name(bit sep_end);
    bit split;
    split = sep_end || name_q.size() == 0;
    foreach (name_q[i]) begin
      if ($urandom_range(0, 14) == 0) push_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_char(name_q[i], 1'b1, !split && (i == name_q.size() - 1));
    end
    if (split) push_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    n_names++;
  endtask

  function automatic logic [7:0] rand_host_char();
    case ($urandom_range(0, 2))
      0:       return CH_LOW_A + 8'($urandom_range(0, 25));
      1:       return CH_ZERO + 8'($urandom_range(0, 9));
      default: return CH_DASH;
    endcase
  endfunction

  // one label of 1..10 tokens: plain chars, \DDD and \X escapes
  function automatic void add_label();
    int ntok;
    ntok = $urandom_range(1, 10);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(0, 9))
        0: begin
          name_q.push_back(CH_BSL);
          repeat (3) name_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        1: begin
          name_q.push_back(CH_BSL);
          name_q.push_back(8'($urandom_range(0, 255)));
        end
        default: name_q.push_back(rand_host_char());
      endcase
    end
  endfunction

  function automatic void build_good_name();
    int nlab;
    name_q.delete();
    nlab = $urandom_range(1, 4);
    for (int k = 0; k < nlab; k++) begin
      if (k > 0) name_q.push_back(CH_DOT);
      add_label();
    end
    if ($urandom_range(0, 1) == 1) name_q.push_back(CH_DOT);  // fully qualified
  endfunction

  // plain-letter labels of exact sizes, for the length limits
  function automatic void build_long(int lens[4]);
    name_q.delete();
    foreach (lens[k]) begin
      if (lens[k] > 0) begin
        if (k > 0) name_q.push_back(CH_DOT);
        repeat (lens[k]) name_q.push_back(CH_LOW_A + 8'($urandom_range(0, 25)));
      end
    end
  endfunction

  function automatic void build_random_name();
    int n;
    case ($urandom_range(0, 9))
      0: begin
        // raw noise, possibly nothing at all
        name_q.delete();
        n = $urandom_range(0, 8);
        repeat (n) name_q.push_back(8'($urandom_range(0, 255)));
      end
      1, 2: begin
        // well-formed name damaged in one way
        build_good_name();
        case ($urandom_range(0, 4))
          0: name_q.insert($urandom_range(0, name_q.size()), CH_DOT);
          1: name_q.push_front(CH_DOT);
          2: name_q.push_back(CH_BSL);
          3: begin
            name_q.push_back(CH_BSL);
            repeat ($urandom_range(1, 2))
              name_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          end
          default: begin
            name_q.push_back(CH_BSL);
            name_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            name_q.push_back(CH_LOW_A + 8'($urandom_range(0, 25)));
          end
        endcase
      end
      default: build_good_name();
    endcase
  endfunction

  initial begin
    int rand_items;
    int idx;
    int before_n;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'd0;
    in_tuser   = 1'b0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed ----
    send_text(".", 1);                    // root name
    send_text("\\.b.", 1);                // escaped dot, trailing dot
    push_char(8'h00, 1'b0, 1'b1);         // empty name
    n_names++;
    push_char(8'hA5, 1'b0, 1'b0);         // no char, no end: ignored
    send_text("\\999", 0);                // decimal escape wraps mod 256
    push_char(8'h00, 1'b0, 1'b1);
    n_names++;
    send_text("\\", 1);                   // trailing backslash
    send_text("\\1z", 1);                 // escape cut after one digit
    send_text("\\12z", 1);                // cut after two digits: most results
    send_text("\\12", 1);                 // name ends inside an escape
    send_text(".a", 1);                   // char after a leading lone dot
    send_text("a..", 1);                  // empty label mid-name
    push_char(8'hFF, 1'b1, 1'b0);         // byte extremes
    push_char(8'h00, 1'b1, 1'b1);
    n_names++;

    // ---- random ----
    rand_items = 0;
    idx = 0;
    while (rand_items < RAND_ITEMS) begin
      case (idx)
        2:  begin build_long('{63, 63, 63, 61}); send_name(0); end  // exactly MAX_NAME
        5:  begin build_long('{63, 63, 63, 62}); send_name(0); end  // one byte too long
        8:  begin build_long('{64, 0, 0, 0});    send_name(1); end  // label over limit
        default: begin
          before_n = n_items;
          build_random_name();
          send_name($urandom_range(0, 3) == 0);
          rand_items += n_items - before_n;
        end
      endcase
      idx++;
      if (rand_items >= QUIET_FROM) quiet = 1'b1;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;

    // ---- drain ----
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d names in %0d input transactions, %0d byte writes checked",
             n_names, n_items, sb.n_writes);
    $display("tb: status ok=%0d long_name=%0d empty=%0d long_label=%0d empty_label=%0d esc=%0d",
             sb.st_tally[ST_OK], sb.st_tally[ST_NAME_LONG], sb.st_tally[ST_EMPTY],
             sb.st_tally[ST_LABEL_LONG], sb.st_tally[ST_EMPTY_LABEL],
             sb.st_tally[ST_BAD_ESC]);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
